>>> hw/rtl/cti_pkg.sv
// cti_pkg: shared widths, knot ROM and stage structs for the cubic table interpolator.
// No dependencies; used by every module in hw/rtl.
package cti_pkg;

    localparam int ROM_KNOTS     = 35;
    localparam int TABLE_SIZE_DEF = 35;
    localparam int OUT_FRAC_DEF  = 20;
    localparam int GUARD_BITS    = 8;

    localparam int WL_W   = 23;  // input wavelength, Q15.8
    localparam int IDX_W  = 6;   // ROM index
    localparam int KWL_W  = 15;  // knot wavelength, integer angstroms
    localparam int KN_W   = 18;  // knot index in units of 1e-5
    localparam int U_W    = 23;  // |x - 256*l|
    localparam int DIFF_W = 15;  // |l_p - l_m|
    localparam int PAIR_W = 2 * U_W;
    localparam int P_W    = 3 * U_W;
    localparam int NP_W   = P_W + KN_W;
    localparam int DD_W   = 2 * DIFF_W;
    localparam int D_W    = 3 * DIFF_W;
    localparam int SCALE_W = 17;
    localparam int D2_W   = D_W + SCALE_W;
    localparam int QB     = 61;  // quotient bits 60..0
    localparam int TERM_W = 61;  // term magnitude, saturates at 2^60
    localparam int SUM_W  = 64;
    localparam int OUT_W  = 22;

    localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(100000);
    localparam logic [TERM_W-1:0] TERM_LIMIT = TERM_W'(1) << 60;

    localparam int TERM_LAT = 3;
    localparam int DIV_LAT  = QB + 2;

    typedef struct packed {
        logic [3:0]            neg;
        logic [3:0][U_W-1:0]   mag;
        logic [3:0][KWL_W-1:0] wl;
        logic [3:0][KN_W-1:0]  n;
    } window_t;

    typedef struct packed {
        logic            neg;
        logic [NP_W-1:0] np;
        logic [D2_W-1:0] den;
    } term_t;

    function automatic logic [KWL_W-1:0] knot_wl(input logic [IDX_W-1:0] k);
        logic [KWL_W-1:0] r;
        case (k)
            6'd0:  r = 15'd3511;   6'd1:  r = 15'd3638;   6'd2:  r = 15'd4047;
            6'd3:  r = 15'd4358;   6'd4:  r = 15'd4416;   6'd5:  r = 15'd4579;
            6'd6:  r = 15'd4658;   6'd7:  r = 15'd4727;   6'd8:  r = 15'd4765;
            6'd9:  r = 15'd4800;   6'd10: r = 15'd4861;   6'd11: r = 15'd4880;
            6'd12: r = 15'd4965;   6'd13: r = 15'd5017;   6'd14: r = 15'd5145;
            6'd15: r = 15'd5320;   6'd16: r = 15'd5461;   6'd17: r = 15'd5876;
            6'd18: r = 15'd5893;   6'd19: r = 15'd6328;   6'd20: r = 15'd6438;
            6'd21: r = 15'd6563;   6'd22: r = 15'd6943;   6'd23: r = 15'd7860;
            6'd24: r = 15'd8210;   6'd25: r = 15'd8300;   6'd26: r = 15'd8521;
            6'd27: r = 15'd9040;   6'd28: r = 15'd10140;  6'd29: r = 15'd10600;
            6'd30: r = 15'd13000;  6'd31: r = 15'd15000;  6'd32: r = 15'd15500;
            6'd33: r = 15'd19701;  6'd34: r = 15'd23254;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [KN_W-1:0] knot_n(input logic [IDX_W-1:0] k);
        logic [KN_W-1:0] r;
        case (k)
            6'd0:  r = 18'd153894; 6'd1:  r = 18'd153648; 6'd2:  r = 18'd153024;
            6'd3:  r = 18'd152669; 6'd4:  r = 18'd152611; 6'd5:  r = 18'd152462;
            6'd6:  r = 18'd152395; 6'd7:  r = 18'd152339; 6'd8:  r = 18'd152310;
            6'd9:  r = 18'd152283; 6'd10: r = 18'd152238; 6'd11: r = 18'd152224;
            6'd12: r = 18'd152165; 6'd13: r = 18'd152130; 6'd14: r = 18'd152049;
            6'd15: r = 18'd151947; 6'd16: r = 18'd151872; 6'd17: r = 18'd151680;
            6'd18: r = 18'd151673; 6'd19: r = 18'd151509; 6'd20: r = 18'd151472;
            6'd21: r = 18'd151432; 6'd22: r = 18'd151322; 6'd23: r = 18'd151106;
            6'd24: r = 18'd151037; 6'd25: r = 18'd151021; 6'd26: r = 18'd150981;
            6'd27: r = 18'd150894; 6'd28: r = 18'd150731; 6'd29: r = 18'd150669;
            6'd30: r = 18'd150371; 6'd31: r = 18'd150130; 6'd32: r = 18'd150068;
            6'd33: r = 18'd149500; 6'd34: r = 18'd148929;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/cti_locate.sv
// cti_locate: three-stage knot search and four-knot window fetch.
// Depends on cti_pkg (knot ROM, window_t).
module cti_locate #(
    parameter int TABLE_SIZE = cti_pkg::TABLE_SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [cti_pkg::WL_W-1:0]   x,
    output logic                       out_valid,
    output logic                       out_flag,
    output cti_pkg::window_t           win
);

    localparam int KNOTS = (TABLE_SIZE < 4) ? 4 :
                           ((TABLE_SIZE > cti_pkg::ROM_KNOTS) ? cti_pkg::ROM_KNOTS : TABLE_SIZE);
    localparam int CNT_W = $clog2(KNOTS + 1);

    logic                     v1_reg, v2_reg, v3_reg;
    logic [cti_pkg::WL_W-1:0] x1_reg, x2_reg;
    logic [KNOTS-1:0]         cmp_reg, cmp_next;
    logic [cti_pkg::IDX_W-1:0] start_reg, start_next;
    logic                     flag2_reg, flag2_next, flag3_reg;
    cti_pkg::window_t         win_reg, win_next;
    logic [CNT_W-1:0]         cnt;
    logic [CNT_W-1:0]         cnt_m2;

    // stage 1: compare against every knot (thermometer code)
    always_comb
    begin
        for (int k = 0; k < KNOTS; k++)
        begin
            cmp_next[k] = x > {cti_pkg::knot_wl(cti_pkg::IDX_W'(k)), 8'b0};
        end
    end

    // stage 2: knots below x -> window start
    always_comb
    begin
        cnt = '0;
        for (int k = 0; k < KNOTS; k++)
        begin
            if (cmp_reg[k])
            begin
                cnt = CNT_W'(k + 1);
            end
        end
        cnt_m2 = cnt - CNT_W'(2);
        flag2_next = (cnt == '0) || (cnt == CNT_W'(KNOTS));
        if (cnt < CNT_W'(2))
        begin
            start_next = '0;
        end
        else if (cnt_m2 > CNT_W'(KNOTS - 4))
        begin
            start_next = cti_pkg::IDX_W'(KNOTS - 4);
        end
        else
        begin
            start_next = cti_pkg::IDX_W'(cnt_m2);
        end
    end

    // stage 3: fetch knots, offsets from x
    always_comb
    begin
        logic [cti_pkg::WL_W-1:0]  xl;
        logic [cti_pkg::IDX_W-1:0] idx;
        for (int j = 0; j < 4; j++)
        begin
            idx = start_reg + cti_pkg::IDX_W'(j);
            win_next.wl[j] = cti_pkg::knot_wl(idx);
            win_next.n[j]  = cti_pkg::knot_n(idx);
            xl = {win_next.wl[j], 8'b0};
            win_next.neg[j] = x2_reg < xl;
            win_next.mag[j] = win_next.neg[j] ? (xl - x2_reg) : (x2_reg - xl);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= x;
        cmp_reg   <= cmp_next;
        x2_reg    <= x1_reg;
        start_reg <= start_next;
        flag2_reg <= flag2_next;
        win_reg   <= win_next;
        flag3_reg <= flag2_reg;
    end

    assign out_valid = v3_reg;
    assign out_flag  = flag3_reg;
    assign win       = win_reg;

endmodule

>>> hw/rtl/cti_term.sv
// cti_term: three-stage product pipeline for one Lagrange term (numerator, divisor, sign).
// Depends on cti_pkg (window_t, term_t).
module cti_term #(
    parameter int POS = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  cti_pkg::window_t win,
    output logic             out_valid,
    output cti_pkg::term_t   term
);

    localparam int OA = (POS == 0) ? 1 : 0;
    localparam int OB = (POS <= 1) ? 2 : 1;
    localparam int OC = (POS <= 2) ? 3 : 2;
    localparam logic BASE_NEG = ((POS % 2) == 0);

    logic v1_reg, v2_reg, v3_reg;
    logic [cti_pkg::PAIR_W-1:0] pair_reg, pair_next;
    logic [cti_pkg::DD_W-1:0]   dd_reg, dd_next;
    logic [cti_pkg::U_W-1:0]    magc_reg;
    logic [cti_pkg::DIFF_W-1:0] dc_reg;
    logic [cti_pkg::KN_W-1:0]   n1_reg, n2_reg;
    logic                       neg1_reg, neg2_reg, neg_next;
    logic [cti_pkg::P_W-1:0]    p3_reg, p3_next;
    logic [cti_pkg::D_W-1:0]    d3_reg, d3_next;
    cti_pkg::term_t             term_reg, term_next;
    logic [cti_pkg::DIFF_W-1:0] da, db, dc;

    function automatic logic [cti_pkg::DIFF_W-1:0] absdiff(
        input logic [cti_pkg::KWL_W-1:0] a,
        input logic [cti_pkg::KWL_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb
    begin
        da = absdiff(win.wl[POS], win.wl[OA]);
        db = absdiff(win.wl[POS], win.wl[OB]);
        dc = absdiff(win.wl[POS], win.wl[OC]);
        pair_next = win.mag[OA] * win.mag[OB];
        dd_next   = da * db;
        neg_next  = BASE_NEG ^ win.neg[OA] ^ win.neg[OB] ^ win.neg[OC];
        p3_next   = pair_reg * magc_reg;
        d3_next   = dd_reg * dc_reg;
        term_next.np  = p3_reg * n2_reg;
        term_next.den = d3_reg * cti_pkg::SCALE;
        term_next.neg = neg2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
        dd_reg   <= dd_next;
        magc_reg <= win.mag[OC];
        dc_reg   <= dc;
        n1_reg   <= win.n[POS];
        neg1_reg <= neg_next;
        p3_reg   <= p3_next;
        d3_reg   <= d3_next;
        n2_reg   <= n1_reg;
        neg2_reg <= neg1_reg;
        term_reg <= term_next;
    end

    assign out_valid = v3_reg;
    assign term      = term_reg;

endmodule

>>> hw/rtl/cti_divider.sv
// cti_divider: restoring divider, one quotient bit per stage, with term saturation.
// Depends on cti_pkg (term_t, widths).
module cti_divider #(
    parameter int OUT_FRAC_BITS = cti_pkg::OUT_FRAC_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  cti_pkg::term_t              term,
    output logic                        out_valid,
    output logic                        out_neg,
    output logic [cti_pkg::TERM_W-1:0]  mag
);

    localparam int QB    = cti_pkg::QB;
    // numerator scale 2^24 shifted by E to 2^(F+8), against an unscaled divisor
    localparam int E     = OUT_FRAC_BITS - 16;
    localparam int NUM_W = cti_pkg::NP_W + ((E > 0) ? E : 0);

    logic [NUM_W-1:0]          num;
    logic [NUM_W-1:0]          rem_reg [0:QB];
    logic [cti_pkg::D2_W-1:0]  den_reg [0:QB];
    logic [QB-1:0]             q_reg   [0:QB];
    logic                      sat_reg [0:QB];
    logic                      neg_reg [0:QB];
    logic                      v_reg   [0:QB];
    logic                      vo_reg, nego_reg;
    logic [cti_pkg::TERM_W-1:0] mag_reg, mag_next;

    generate
        if (E >= 0)
        begin : g_up
            assign num = NUM_W'(term.np) << E;
        end
        else
        begin : g_down
            assign num = NUM_W'(term.np >> (-E));
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= term.den;
        q_reg[0]   <= '0;
        sat_reg[0] <= (num >> QB) >= NUM_W'(term.den);
        neg_reg[0] <= term.neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_stage
        localparam int B = QB - 1 - s;
        logic ge;
        assign ge = (rem_reg[s] >> B) >= NUM_W'(den_reg[s]);

        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= ge ? (rem_reg[s] - (NUM_W'(den_reg[s]) << B)) : rem_reg[s];
            den_reg[s+1] <= den_reg[s];
            q_reg[s+1]   <= {q_reg[s][QB-2:0], ge};
            sat_reg[s+1] <= sat_reg[s];
            neg_reg[s+1] <= neg_reg[s];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end
    end

    always_comb
    begin
        if (sat_reg[QB] || (q_reg[QB] > cti_pkg::TERM_LIMIT))
        begin
            mag_next = cti_pkg::TERM_LIMIT;
        end
        else
        begin
            mag_next = q_reg[QB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        nego_reg <= neg_reg[QB];
    end

    assign out_valid = vo_reg;
    assign out_neg   = nego_reg;
    assign mag       = mag_reg;

endmodule

>>> hw/rtl/cubic_table_interpolator.sv
// cubic_table_interpolator: top level, four-point Lagrange cubic over the knot ROM.
// Depends on cti_pkg, cti_locate, cti_term, cti_divider.
//
// Usage:
//   Command channel: drive wavelength_q8 (Q15.8 angstroms) and raise start.
//   A transfer happens at each rising edge with start high and busy low.
//   busy is always low here: the pipeline takes one transfer every cycle.
//   Result channel: done pulses for one cycle with index_q20 (unsigned Q2.20,
//   saturated) and out_of_range. The receiver has no way to stall, so every
//   result must be taken in the cycle it is shown.
//   Throughput: one result per cycle; every stage, including each of the 61
//   divider stages (one quotient bit per stage, four lanes side by side),
//   takes a new transfer every cycle.
//   Stages: knot compare, window start, ROM fetch (3); products (3);
//   divider (63); signed sum (1); round and clamp (1).
//   Reset: rst_n clears all valid bits; items in flight are dropped and no
//   done pulse appears until a new transfer has gone through the pipeline.
//   Results leave in acceptance order; nothing is held or reordered.
module cubic_table_interpolator #(
    parameter int TABLE_SIZE    = cti_pkg::TABLE_SIZE_DEF,
    parameter int OUT_FRAC_BITS = cti_pkg::OUT_FRAC_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [cti_pkg::WL_W-1:0]    wavelength_q8,
    output logic                        done,
    output logic [cti_pkg::OUT_W-1:0]   index_q20,
    output logic                        out_of_range
);

    localparam int SUM_W    = cti_pkg::SUM_W;
    localparam int FLAG_DLY = cti_pkg::TERM_LAT + cti_pkg::DIV_LAT;
    // largest index code: 2^(F+2)-1, capped by the 22-bit field
    localparam logic [SUM_W-1:0] YMAX = (OUT_FRAC_BITS >= 20) ?
        ((SUM_W'(1) << cti_pkg::OUT_W) - SUM_W'(1)) :
        ((SUM_W'(1) << (OUT_FRAC_BITS + 2)) - SUM_W'(1));
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (cti_pkg::GUARD_BITS - 1);

    logic             loc_valid, loc_flag;
    cti_pkg::window_t win;
    logic [3:0]       term_valid, div_valid, div_neg;
    cti_pkg::term_t   term [4];
    logic [cti_pkg::TERM_W-1:0] mag [4];

    logic             flag_dly_reg [0:FLAG_DLY-1];
    logic             sum_v_reg, sum_flag_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic             done_reg, flag_reg;
    logic [cti_pkg::OUT_W-1:0] index_reg, index_next;
    logic [SUM_W-1:0] rnd;

    assign busy = 1'b0;

    cti_locate #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .x         (wavelength_q8),
        .out_valid (loc_valid),
        .out_flag  (loc_flag),
        .win       (win)
    );

    // one lane per knot of the window
    for (genvar p = 0; p < 4; p++)
    begin : g_lane
        cti_term #(
            .POS (p)
        ) u_term (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (loc_valid),
            .win       (win),
            .out_valid (term_valid[p]),
            .term      (term[p])
        );

        cti_divider #(
            .OUT_FRAC_BITS (OUT_FRAC_BITS)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (term_valid[p]),
            .term      (term[p]),
            .out_valid (div_valid[p]),
            .out_neg   (div_neg[p]),
            .mag       (mag[p])
        );
    end

    // out-of-range flag rides alongside the product and divider lanes
    always_ff @(posedge clk)
    begin
        flag_dly_reg[0] <= loc_flag;
        for (int k = 1; k < FLAG_DLY; k++)
        begin
            flag_dly_reg[k] <= flag_dly_reg[k-1];
        end
    end

    // signed sum of the four terms
    always_comb
    begin
        logic signed [SUM_W-1:0] t;
        sum_next = '0;
        for (int p = 0; p < 4; p++)
        begin
            t = SUM_W'(mag[p]);
            sum_next = div_neg[p] ? (sum_next - t) : (sum_next + t);
        end
    end

    // drop guard bits with round half up, clamp to the field
    always_comb
    begin
        rnd = (SUM_W'(sum_reg) + HALF) >> cti_pkg::GUARD_BITS;
        if (sum_reg <= 0)
        begin
            index_next = '0;
        end
        else if (rnd > YMAX)
        begin
            index_next = cti_pkg::OUT_W'(YMAX);
        end
        else
        begin
            index_next = cti_pkg::OUT_W'(rnd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            sum_v_reg <= &div_valid;
            done_reg  <= sum_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        sum_flag_reg <= flag_dly_reg[FLAG_DLY-1];
        index_reg    <= index_next;
        flag_reg     <= sum_flag_reg;
    end

    assign done         = done_reg;
    assign index_q20    = index_reg;
    assign out_of_range = flag_reg;

endmodule
